[rtl/core/pgr_pkg.sv]
// Shared constants, types and command codes for the page replacement block.
package pgr_pkg;

  // Geometry
  localparam int PAGES      = 32;
  localparam int FRAMES     = 16;
  localparam int PAGE_BYTES = 200;

  localparam int ADDR_W = 16;
  localparam int PAGE_W = $clog2(PAGES);
  localparam int SLOT_W = $clog2(FRAMES);
  localparam int CNT_W  = SLOT_W + 1;

  // Result field widths
  localparam int OUT_PAGE_W = 5;
  localparam int OUT_SLOT_W = 4;
  localparam int FAULT_W    = 32;

  // Address / PAGE_BYTES by reciprocal multiply, exact for any ADDR_W-bit address
  localparam int              DIV_SHIFT = ADDR_W + $clog2(PAGE_BYTES);
  localparam int              MUL_W     = ADDR_W + 1;
  localparam int              PROD_W    = ADDR_W + MUL_W;
  localparam logic [63:0]     DIV_MUL64 = ((64'd1 << DIV_SHIFT) + 64'(PAGE_BYTES) - 64'd1)
                                          / 64'(PAGE_BYTES);
  localparam logic [MUL_W-1:0] DIV_MUL  = DIV_MUL64[MUL_W-1:0];

  // APB register map
  localparam int          APB_AW        = 3;
  localparam logic        REG_POLICY    = 1'b0;
  localparam logic        REG_PREPAGING = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CLASSIFY,
    ST_DECIDE,
    ST_SEARCH,
    ST_SHIFT,
    ST_RESULT
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_INIT,
    OP_LOAD,
    OP_MUL,
    OP_CLASSIFY,
    OP_FILL,
    OP_EVICT,
    OP_SEARCH_INIT,
    OP_SEARCH_STEP,
    OP_SHIFT
  } dp_op_e;

  typedef struct packed {
    logic policy_lru;
    logic prepaging;
    logic init;
  } cfg_t;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic oor;
    logic hit;
    logic free_slot;
    logic match;
    logic last;
  } status_t;

endpackage

[rtl/core/pgr_apb.sv]
// APB configuration registers; a write raises a one-cycle state reinit request.
module pgr_apb (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [pgr_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output pgr_pkg::cfg_t             cfg_o
);
  import pgr_pkg::*;

  logic policy_q, policy_d;
  logic prep_q, prep_d;
  logic init_q, init_d;
  logic wr;
  logic reg_idx;

  // word-aligned map, byte offset bits ignored
  assign reg_idx = paddr[2];
  assign wr      = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_comb begin
    policy_d = policy_q;
    prep_d   = prep_q;
    init_d   = 1'b0;
    if (wr) begin
      init_d = 1'b1;
      unique case (reg_idx)
        REG_POLICY:    policy_d = pwdata[0];
        REG_PREPAGING: prep_d   = pwdata[0];
        default:       init_d   = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= 1'b0;
      prep_q   <= 1'b0;
      init_q   <= 1'b0;
    end else begin
      policy_q <= policy_d;
      prep_q   <= prep_d;
      init_q   <= init_d;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_POLICY:    prdata = {31'd0, policy_q};
      REG_PREPAGING: prdata = {31'd0, prep_q};
      default:       prdata = 32'd0;
    endcase
  end

  assign cfg_o = '{policy_lru: policy_q, prepaging: prep_q, init: init_q};

endmodule

[rtl/core/pgr_ctrl.sv]
// Sequencer: steps each transfer through divide, lookup, update and result.
module pgr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  pgr_pkg::cfg_t    cfg_i,
  input  pgr_pkg::status_t status_i,
  output pgr_pkg::cmd_t    cmd_o,
  output logic             busy_o,
  output logic             done_o
);
  import pgr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE) | cfg_i.init;

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NONE;
    done_o    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (cfg_i.init) begin
          cmd_o.op = OP_INIT;
        end else if (start_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.op = OP_MUL;
        state_d  = ST_CLASSIFY;
      end
      ST_CLASSIFY: begin
        cmd_o.op = OP_CLASSIFY;
        state_d  = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (status_i.oor) begin
          state_d = ST_RESULT;
        end else if (status_i.hit) begin
          if (cfg_i.policy_lru) begin
            cmd_o.op = OP_SEARCH_INIT;
            state_d  = ST_SEARCH;
          end else begin
            state_d = ST_RESULT;
          end
        end else if (status_i.free_slot) begin
          cmd_o.op = OP_FILL;
          state_d  = ST_RESULT;
        end else begin
          cmd_o.op = OP_EVICT;
          state_d  = ST_SHIFT;
        end
      end
      ST_SEARCH: begin
        cmd_o.op = OP_SEARCH_STEP;
        if (status_i.match) begin
          state_d = ST_SHIFT;
        end else if (status_i.last) begin
          state_d = ST_RESULT;
        end
      end
      ST_SHIFT: begin
        cmd_o.op = OP_SHIFT;
        state_d  = ST_RESULT;
      end
      ST_RESULT: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

[rtl/core/pgr_dp.sv]
// Datapath: page tables, frame owners, recency order, counters and result registers.
module pgr_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pgr_pkg::cfg_t                 cfg_i,
  input  pgr_pkg::cmd_t                 cmd_i,
  input  logic [pgr_pkg::ADDR_W-1:0]    logical_address_i,
  output pgr_pkg::status_t              status_o,
  output logic [pgr_pkg::OUT_PAGE_W-1:0] page_number_o,
  output logic                          out_of_range_o,
  output logic                          fault_o,
  output logic [pgr_pkg::OUT_SLOT_W-1:0] frame_slot_o,
  output logic                          evicted_o,
  output logic [pgr_pkg::OUT_PAGE_W-1:0] evicted_page_o,
  output logic [pgr_pkg::FAULT_W-1:0]   fault_total_o
);
  import pgr_pkg::*;

  // state
  logic [PAGES-1:0]              resident_q;
  logic [SLOT_W-1:0]             page_frame_q [PAGES];
  logic [PAGE_W-1:0]             owner_q      [FRAMES];
  logic [FRAMES-1:0]             used_q;
  logic [SLOT_W-1:0]             order_q      [FRAMES];
  logic [CNT_W-1:0]              fill_q;
  logic [FAULT_W-1:0]            faults_q;

  // per-transfer working registers
  logic [ADDR_W-1:0]             addr_q;
  logic [PROD_W-1:0]             prod_q;
  logic [PAGE_W-1:0]             page_q;
  logic                          oor_q, hit_q;
  logic [SLOT_W-1:0]             target_q, idx_q, pos_q;
  logic [CNT_W-1:0]              len_q;

  // result registers
  logic [OUT_PAGE_W-1:0]         res_page_q;
  logic                          res_fault_q, res_evicted_q;
  logic [SLOT_W-1:0]             res_slot_q;
  logic [PAGE_W-1:0]             res_evpage_q;

  // combinational
  logic [ADDR_W-1:0]             quot;
  logic                          quot_oor;
  logic [PAGE_W-1:0]             quot_page;
  logic [SLOT_W-1:0]             victim, fill_slot;
  logic [CNT_W-1:0]              idx_ext;
  logic                          match, last;
  logic [SLOT_W-1:0]             order_up   [FRAMES];
  logic [SLOT_W-1:0]             order_next [FRAMES];

  assign quot      = ADDR_W'(prod_q >> DIV_SHIFT);
  assign quot_oor  = quot >= ADDR_W'(PAGES);
  assign quot_page = quot[PAGE_W-1:0];
  assign victim    = order_q[0];
  assign fill_slot = fill_q[SLOT_W-1:0];
  assign idx_ext   = {1'b0, idx_q};
  assign match     = (idx_ext < len_q) && (order_q[idx_q] == target_q);
  assign last      = (idx_ext + CNT_W'(1)) >= len_q;

  // move target from pos to the tail of the first len entries
  always_comb begin
    for (int i = 0; i < FRAMES - 1; i++) begin
      order_up[i] = order_q[i + 1];
    end
    order_up[FRAMES-1] = target_q;
    for (int i = 0; i < FRAMES; i++) begin
      if (CNT_W'(i) < {1'b0, pos_q} || CNT_W'(i) >= len_q) begin
        order_next[i] = order_q[i];
      end else if (CNT_W'(i) == len_q - CNT_W'(1)) begin
        order_next[i] = target_q;
      end else begin
        order_next[i] = order_up[i];
      end
    end
  end

  assign status_o = '{
    oor:       oor_q,
    hit:       hit_q,
    free_slot: !cfg_i.prepaging && (fill_q < CNT_W'(FRAMES)),
    match:     match,
    last:      last
  };

  // page/frame tables and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resident_q <= '0;
      used_q     <= '0;
      fill_q     <= '0;
      faults_q   <= '0;
      for (int p = 0; p < PAGES; p++) begin
        page_frame_q[p] <= '0;
      end
      for (int f = 0; f < FRAMES; f++) begin
        owner_q[f] <= '0;
        order_q[f] <= SLOT_W'(f);
      end
    end else begin
      unique case (cmd_i.op)
        OP_INIT: begin
          fill_q   <= '0;
          faults_q <= '0;
          for (int p = 0; p < PAGES; p++) begin
            resident_q[p]   <= cfg_i.prepaging && (p < FRAMES);
            page_frame_q[p] <= (cfg_i.prepaging && (p < FRAMES)) ? SLOT_W'(p) : '0;
          end
          for (int f = 0; f < FRAMES; f++) begin
            used_q[f]  <= cfg_i.prepaging && (f < PAGES);
            owner_q[f] <= (cfg_i.prepaging && (f < PAGES)) ? PAGE_W'(f) : '0;
            order_q[f] <= SLOT_W'(f);
          end
        end
        OP_FILL: begin
          faults_q                <= faults_q + FAULT_W'(1);
          fill_q                  <= fill_q + CNT_W'(1);
          order_q[fill_slot]      <= fill_slot;
          owner_q[fill_slot]      <= page_q;
          used_q[fill_slot]       <= 1'b1;
          resident_q[page_q]      <= 1'b1;
          page_frame_q[page_q]    <= fill_slot;
        end
        OP_EVICT: begin
          faults_q <= faults_q + FAULT_W'(1);
          if (used_q[victim]) begin
            resident_q[owner_q[victim]] <= 1'b0;
          end
          owner_q[victim]      <= page_q;
          used_q[victim]       <= 1'b1;
          resident_q[page_q]   <= 1'b1;
          page_frame_q[page_q] <= victim;
        end
        OP_SHIFT: begin
          for (int f = 0; f < FRAMES; f++) begin
            order_q[f] <= order_next[f];
          end
        end
        default: ;
      endcase
    end
  end

  // working and result registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: addr_q <= logical_address_i;
      OP_MUL:  prod_q <= PROD_W'(addr_q) * PROD_W'(DIV_MUL);
      OP_CLASSIFY: begin
        page_q        <= quot_page;
        oor_q         <= quot_oor;
        hit_q         <= !quot_oor && resident_q[quot_page];
        res_page_q    <= quot[OUT_PAGE_W-1:0];
        res_fault_q   <= 1'b0;
        res_slot_q    <= (!quot_oor && resident_q[quot_page]) ? page_frame_q[quot_page] : '0;
        res_evicted_q <= 1'b0;
        res_evpage_q  <= '0;
      end
      OP_FILL: begin
        res_fault_q <= 1'b1;
        res_slot_q  <= fill_slot;
      end
      OP_EVICT: begin
        res_fault_q   <= 1'b1;
        res_slot_q    <= victim;
        res_evicted_q <= used_q[victim];
        res_evpage_q  <= used_q[victim] ? owner_q[victim] : '0;
        target_q      <= victim;
        pos_q         <= '0;
        len_q         <= CNT_W'(FRAMES);
      end
      OP_SEARCH_INIT: begin
        target_q <= res_slot_q;
        idx_q    <= '0;
        pos_q    <= '0;
        len_q    <= cfg_i.prepaging ? CNT_W'(FRAMES) : fill_q;
      end
      OP_SEARCH_STEP: begin
        if (match) begin
          pos_q <= idx_q;
        end
        idx_q <= idx_q + SLOT_W'(1);
      end
      default: ;
    endcase
  end

  assign page_number_o  = res_page_q;
  assign out_of_range_o = oor_q;
  assign fault_o        = res_fault_q;
  assign frame_slot_o   = OUT_SLOT_W'(res_slot_q);
  assign evicted_o      = res_evicted_q;
  assign evicted_page_o = OUT_PAGE_W'(res_evpage_q);
  assign fault_total_o  = faults_q;

endmodule

[rtl/core/page_replacement_fifo_lru.sv]
// Top level of the FIFO / LRU page replacement block.
//
// Usage:
//  - Command channel: a transfer is taken at a rising edge with start_i high and
//    busy_o low. logical_address_i is sampled there; the page number is the
//    address divided by the page size.
//  - Result channel: done_o is high for exactly one cycle with the result fields;
//    the receiver cannot stall, so results are never held back or dropped.
//  - Sequence from accept to done_o: divide, classify and decide states, then
//    the result state for an out-of-range page, a hit under FIFO and a fill of
//    a free frame; a replacement adds a shift state; a hit under LRU adds the
//    recency search, reading one recency entry per cycle, and a shift on a match.
//    busy_o drops the cycle after done_o, so one transfer is in flight at a time.
//  - Config: APB, register 0 at 0x0 (policy, 0 FIFO / 1 LRU), register 1 at
//    0x4 (prepaging). Any write reinitialises the tables in the following cycle,
//    during which busy_o is high. Write only while idle.
//  - Reset: async, active low; FIFO, demand paging, all frames free, recency
//    order ascending and the fault total cleared.
module page_replacement_fifo_lru (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // command channel
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [pgr_pkg::ADDR_W-1:0]     logical_address_i,
  // result channel
  output logic                           done_o,
  output logic [pgr_pkg::OUT_PAGE_W-1:0] page_number_o,
  output logic                           out_of_range_o,
  output logic                           fault_o,
  output logic [pgr_pkg::OUT_SLOT_W-1:0] frame_slot_o,
  output logic                           evicted_o,
  output logic [pgr_pkg::OUT_PAGE_W-1:0] evicted_page_o,
  output logic [pgr_pkg::FAULT_W-1:0]    fault_total_o,
  // APB configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pgr_pkg::APB_AW-1:0]     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import pgr_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  pgr_apb u_apb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer: owns the handshake and issues one datapath op per cycle
  pgr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .cfg_i    (cfg),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  // tables, recency order and result registers
  pgr_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .cmd_i             (cmd),
    .logical_address_i (logical_address_i),
    .status_o          (status),
    .page_number_o     (page_number_o),
    .out_of_range_o    (out_of_range_o),
    .fault_o           (fault_o),
    .frame_slot_o      (frame_slot_o),
    .evicted_o         (evicted_o),
    .evicted_page_o    (evicted_page_o),
    .fault_total_o     (fault_total_o)
  );

endmodule

[bench/tb_page_replacement_fifo_lru.sv]
// Self-checking testbench for the FIFO / LRU page replacement block.
module tb_page_replacement_fifo_lru;
  import pgr_pkg::*;

  // One translation as seen on the result ports
  typedef struct packed {
    logic [OUT_PAGE_W-1:0] page;
    logic                  oor;
    logic                  fault;
    logic [OUT_SLOT_W-1:0] slot;
    logic                  evicted;
    logic [OUT_PAGE_W-1:0] ev_page;
    logic [FAULT_W-1:0]    total;
  } xlat_t;

  // Directed plan: address transfers, or a register write between them
  typedef enum logic [1:0] {
    ROW_XLAT,
    ROW_POLICY,
    ROW_PREPAGING
  } row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [ADDR_W-1:0] value;
    logic              known;  // want is typed in, not predicted
    xlat_t             want;
  } row_t;

  localparam int       ITEMS_PER_PHASE = 192;
  localparam bit [5:0] PHASE_LRU       = 6'b010110;
  localparam bit [5:0] PHASE_PREPAGE   = 6'b101010;
  localparam int       MAX_PRINTS      = 60;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start_i = 1'b0;
  logic                  busy_o;
  logic [ADDR_W-1:0]     logical_address_i = '0;
  logic                  done_o;
  logic [OUT_PAGE_W-1:0] page_number_o;
  logic                  out_of_range_o;
  logic                  fault_o;
  logic [OUT_SLOT_W-1:0] frame_slot_o;
  logic                  evicted_o;
  logic [OUT_PAGE_W-1:0] evicted_page_o;
  logic [FAULT_W-1:0]    fault_total_o;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_AW-1:0]     paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  page_replacement_fifo_lru DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .logical_address_i (logical_address_i),
    .done_o            (done_o),
    .page_number_o     (page_number_o),
    .out_of_range_o    (out_of_range_o),
    .fault_o           (fault_o),
    .frame_slot_o      (frame_slot_o),
    .evicted_o         (evicted_o),
    .evicted_page_o    (evicted_page_o),
    .fault_total_o     (fault_total_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop, far beyond the slowest legal run
  initial begin
    #3000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor: shadow copy of the page table, frame table and recency list.
  // ---------------------------------------------------------------------------
  logic                  lru_mode;
  logic                  prepage_mode;
  logic                  page_resident [PAGES];
  logic [SLOT_W-1:0]     page_slot     [PAGES];
  logic [PAGE_W-1:0]     slot_owner    [FRAMES];
  logic                  slot_used     [FRAMES];
  logic [SLOT_W-1:0]     recency       [FRAMES];  // head = oldest / least recent
  int unsigned           fill_level;
  logic [FAULT_W-1:0]    faults_seen;

  xlat_t                 translations_due [$];
  int unsigned           mismatches;
  int unsigned           idle_pct;

  // Any register write (and reset) rebuilds the tables from scratch
  function automatic void rebuild_tables();
    for (int p = 0; p < PAGES; p++) begin
      page_resident[p] = 1'b0;
      page_slot[p]     = '0;
    end
    for (int s = 0; s < FRAMES; s++) begin
      slot_owner[s] = '0;
      slot_used[s]  = 1'b0;
      recency[s]    = SLOT_W'(s);
    end
    fill_level  = 0;
    faults_seen = '0;
    if (prepage_mode) begin
      for (int s = 0; s < FRAMES && s < PAGES; s++) begin
        page_resident[s] = 1'b1;
        page_slot[s]     = SLOT_W'(s);
        slot_owner[s]    = PAGE_W'(s);
        slot_used[s]     = 1'b1;
      end
    end
  endfunction

  // Move a slot to the tail of the first len recency entries
  function automatic void promote_slot(logic [SLOT_W-1:0] slot, int unsigned len);
    int unsigned pos;
    if (len > FRAMES) len = FRAMES;
    pos = len;
    for (int i = 0; i < len; i++) begin
      if (recency[i] == slot && pos == len) pos = i;
    end
    if (pos >= len) return;
    for (int i = pos; i + 1 < len; i++) recency[i] = recency[i + 1];
    recency[len - 1] = slot;
  endfunction

  function automatic xlat_t translate_address(logic [ADDR_W-1:0] addr);
    xlat_t       r;
    int unsigned pg;
    r  = '0;
    pg = addr / PAGE_BYTES;
    r.page = OUT_PAGE_W'(pg);
    if (pg >= PAGES) begin
      r.oor = 1'b1;                          // flagged, tables untouched
    end else if (page_resident[pg]) begin
      r.slot = page_slot[pg];
      if (lru_mode) promote_slot(r.slot, prepage_mode ? FRAMES : fill_level);
    end else begin
      r.fault     = 1'b1;
      faults_seen = faults_seen + 1'b1;
      if (!prepage_mode && fill_level < FRAMES) begin
        r.slot              = SLOT_W'(fill_level);
        recency[fill_level] = r.slot;
        fill_level++;
      end else begin
        r.slot = recency[0];
        promote_slot(r.slot, FRAMES);
        if (slot_used[r.slot]) begin
          r.evicted = 1'b1;
          r.ev_page = slot_owner[r.slot];
          page_resident[slot_owner[r.slot]] = 1'b0;
        end
      end
      slot_owner[r.slot] = PAGE_W'(pg);
      slot_used[r.slot]  = 1'b1;
      page_resident[pg]  = 1'b1;
      page_slot[pg]      = r.slot;
    end
    r.total = faults_seen;
    return r;
  endfunction

  task automatic log_mismatch(input string msg);
    if (mismatches < MAX_PRINTS) $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every done_o strobe is matched against the oldest
  // outstanding translation. Sampling at the edge sees pre-edge values.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    xlat_t want;
    if (rst_ni && done_o) begin
      if (translations_due.size() == 0) begin
        log_mismatch("result transfer with nothing outstanding");
      end else begin
        want = translations_due.pop_front();
        if (page_number_o !== want.page)
          log_mismatch($sformatf("page_number %0d, want %0d", page_number_o, want.page));
        if (out_of_range_o !== want.oor)
          log_mismatch($sformatf("out_of_range %0b, want %0b", out_of_range_o, want.oor));
        if (fault_o !== want.fault)
          log_mismatch($sformatf("fault %0b, want %0b", fault_o, want.fault));
        if (frame_slot_o !== want.slot)
          log_mismatch($sformatf("frame_slot %0d, want %0d", frame_slot_o, want.slot));
        if (evicted_o !== want.evicted)
          log_mismatch($sformatf("evicted %0b, want %0b", evicted_o, want.evicted));
        if (evicted_page_o !== want.ev_page)
          log_mismatch($sformatf("evicted_page %0d, want %0d", evicted_page_o,
                                 want.ev_page));
        if (fault_total_o !== want.total)
          log_mismatch($sformatf("fault_total %0d, want %0d", fault_total_o, want.total));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Command side. Called just after a rising edge; start_i stays high across
  // back-to-back transfers so it never gets two updates in one step.
  // ---------------------------------------------------------------------------
  task automatic send_address(input logic [ADDR_W-1:0] addr, input logic known,
                              input xlat_t typed);
    xlat_t       want;
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    want = translate_address(addr);
    if (known) want = typed;
    start_i           <= 1'b1;
    logical_address_i <= addr;
    do @(posedge clk_i); while (busy_o);
    translations_due.push_back(want);
  endtask

  // Quiesce the block: drop start, let every result drain, wait for idle
  task automatic settle_idle();
    start_i <= 1'b0;
    while (translations_due.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // One APB transfer; leaves psel/penable up so a following transfer can
  // start in the same step without a second update to them.
  task automatic apb_transfer(input logic wr, input logic idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
  endtask

  // Write a register (junk in the upper bits), mirror it, then read it back
  task automatic reconfigure(input logic idx, input logic v);
    logic [31:0] wdata;
    logic [31:0] rdata;
    settle_idle();
    wdata    = $urandom;
    wdata[0] = v;
    apb_transfer(1'b1, idx, wdata, rdata);
    if (idx == REG_POLICY) lru_mode = v;
    else prepage_mode = v;
    rebuild_tables();
    apb_transfer(1'b0, idx, '0, rdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rdata[0] !== v)
      log_mismatch($sformatf("register %0d reads %0b, want %0b", idx, rdata[0], v));
  endtask

  function automatic row_t xlat_row(logic [ADDR_W-1:0] a);
    row_t r;
    r       = '0;
    r.kind  = ROW_XLAT;
    r.value = a;
    return r;
  endfunction

  function automatic row_t known_row(logic [ADDR_W-1:0] a, int pg, int oor, int flt,
                                     int slot, int ev, int evp, int total);
    row_t r;
    r       = xlat_row(a);
    r.known = 1'b1;
    r.want  = '{page: OUT_PAGE_W'(pg), oor: oor[0], fault: flt[0],
                slot: OUT_SLOT_W'(slot), evicted: ev[0], ev_page: OUT_PAGE_W'(evp),
                total: FAULT_W'(total)};
    return r;
  endfunction

  function automatic row_t cfg_row(row_kind_e k, logic v);
    row_t r;
    r       = '0;
    r.kind  = k;
    r.value = ADDR_W'(v);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    row_t              plan [$];
    int unsigned       pick;
    int unsigned       pg;
    int unsigned       last_page;
    int unsigned       hot_base;
    logic [ADDR_W-1:0] addr;

    mismatches   = 0;
    idle_pct     = 23;
    lru_mode     = 1'b0;
    prepage_mode = 1'b0;
    rebuild_tables();
    last_page = 0;
    hot_base  = 0;

    // Out-of-reset FIFO/demand first, then LRU/demand, LRU/prepaged,
    // FIFO/prepaged. Typed rows: first fill, hit, out-of-range extremes
    // (top address truncates to page 7), first replacement in prepaged mode.
    plan = '{
      known_row(16'd0,     0, 0, 1,  0, 0, 0, 1),
      known_row(16'd199,   0, 0, 0,  0, 0, 0, 1),
      known_row(16'hFFFF,  7, 1, 0,  0, 0, 0, 1),
      known_row(16'd6400,  0, 1, 0,  0, 0, 0, 1),
      known_row(16'd6399, 31, 0, 1,  1, 0, 0, 2),
      xlat_row(16'd200),
      xlat_row(16'd6399),
      cfg_row(ROW_POLICY, 1'b1),
      known_row(16'd400,   2, 0, 1,  0, 0, 0, 1),
      xlat_row(16'd600),
      xlat_row(16'd800),
      xlat_row(16'd401),
      xlat_row(16'd6401),
      cfg_row(ROW_PREPAGING, 1'b1),
      known_row(16'd1000,  5, 0, 0,  5, 0, 0, 0),
      known_row(16'd4000, 20, 0, 1,  0, 1, 0, 1),
      xlat_row(16'd0),
      xlat_row(16'd1199),
      cfg_row(ROW_POLICY, 1'b0),
      known_row(16'd3199, 15, 0, 0, 15, 0, 0, 0),
      known_row(16'd3200, 16, 0, 1,  0, 1, 0, 1),
      xlat_row(16'd3000),
      xlat_row(16'd6200),
      cfg_row(ROW_PREPAGING, 1'b0),
      known_row(16'hFFFF,  7, 1, 0,  0, 0, 0, 0)
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_POLICY: begin
          reconfigure(REG_POLICY, plan[i].value[0]);
        end
        ROW_PREPAGING: begin
          reconfigure(REG_PREPAGING, plan[i].value[0]);
        end
        default: begin
          send_address(plan[i].value, plan[i].known, plan[i].want);
        end
      endcase
    end

    // Random phases: sender idles 23% then 71% then never, every mode
    // combination visited. Most traffic sits on a drifting hot set a bit
    // larger than the frame count so hits and replacements both occur.
    for (int ph = 0; ph < 6; ph++) begin
      reconfigure(REG_POLICY, PHASE_LRU[ph]);
      reconfigure(REG_PREPAGING, PHASE_PREPAGE[ph]);
      idle_pct = (ph < 2) ? 23 : (ph < 4) ? 71 : 0;
      repeat (ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 99) < 5) hot_base = $urandom_range(0, PAGES - 18);
        pick = $urandom_range(0, 99);
        if (pick < 90) begin
          if (pick < 15) pg = last_page;
          else if (pick < 60) pg = hot_base + $urandom_range(0, 17);
          else pg = $urandom_range(0, PAGES - 1);
          if (pick >= 82) addr = ADDR_W'($urandom_range(PAGES * PAGE_BYTES, 65535));
          else addr = ADDR_W'(pg * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1));
          if (pick < 82) last_page = pg;
        end else begin
          addr = ADDR_W'($urandom);         // full-width noise, mostly out of range
        end
        send_address(addr, 1'b0, '0);
      end
    end

    // Drain, then allow the longest LRU search before judging
    start_i <= 1'b0;
    for (int w = 0; w < 2000 && translations_due.size() != 0; w++) @(posedge clk_i);
    repeat (FRAMES + 8) @(posedge clk_i);
    if (translations_due.size() != 0)
      log_mismatch($sformatf("%0d results never arrived", translations_due.size()));

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
